// ===== rtl/core/utf8tx_pkg.sv =====
// Shared types and constants for the UTF-16/UCS-4 to UTF-8 transcoder.
// No dependencies; design files use scoped names and the testbench imports it.
package utf8tx_pkg;

  // byte_order register codes (code 7 behaves as BO_BYTES)
  localparam logic [2:0] BO_BYTES     = 3'd0;
  localparam logic [2:0] BO_UCS4      = 3'd1;
  localparam logic [2:0] BO_UCS4_4321 = 3'd2;
  localparam logic [2:0] BO_UCS4_3412 = 3'd3;
  localparam logic [2:0] BO_UCS4_2143 = 3'd4;
  localparam logic [2:0] BO_UCS2      = 3'd5;
  localparam logic [2:0] BO_UCS2_SWAP = 3'd6;

  localparam int CP_W = 23;                          // code points up to 0x7FFFFF
  localparam logic [31:0] CP_MAX     = 32'h007F_FFFF;
  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] PLANE1     = 21'h01_0000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // What the back end must produce for one queued item
  typedef enum logic [1:0] {
    KIND_RAW = 2'd0,   // one byte, copied through
    KIND_CP  = 2'd1,   // code point to encode as UTF-8
    KIND_ERR = 2'd2    // single error result
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CP_W-1:0]  cp;
  } entry_t;

endpackage

// ===== rtl/core/utf8tx_unit_if.sv =====
// Input channel of the transcoder: one raw code unit per transfer.
// Depends on nothing.
interface utf8tx_unit_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_word;
  logic        stream_end;

  modport source (output valid, output unit_word, output stream_end, input ready);
  modport sink   (input valid, input unit_word, input stream_end, output ready);
endinterface

// ===== rtl/core/utf8tx_byte_if.sv =====
// Output channel of the transcoder: one UTF-8 byte (or error marker) per transfer.
// Depends on nothing.
interface utf8tx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       error;

  modport source (output valid, output out_byte, output run_last, output error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input error, output ready);
endinterface

// ===== rtl/core/utf8tx_front.sv =====
// Front end: holds byte_order, accepts code units, undoes byte swaps, pairs
// surrogates and tracks the halt state. Pushes one entry per result run.
// Depends on utf8tx_pkg and utf8tx_unit_if.
module utf8tx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_wdata,
  utf8tx_unit_if.sink         units,
  input  logic                q_full,
  output logic                push,
  output utf8tx_pkg::entry_t  push_entry
);

  logic [2:0]  byte_order;
  logic        halted, halted_next;
  logic        held_valid, held_valid_next;
  logic [15:0] held, held_next;

  logic        accept;
  logic        last;
  logic [31:0] w;
  logic [31:0] cp32;
  logic [15:0] u;
  logic        u_hi, u_lo, h_hi, h_lo;
  logic [20:0] pair;
  logic        has_result;

  assign units.ready = !q_full;
  assign accept      = units.valid && units.ready;
  assign w           = units.unit_word;
  assign last        = units.stream_end;

  always_comb begin
    u = (byte_order == utf8tx_pkg::BO_UCS2_SWAP) ? {w[7:0], w[15:8]} : w[15:0];
  end

  assign u_hi = (u >= utf8tx_pkg::SUR_HI_MIN) && (u <= utf8tx_pkg::SUR_HI_MAX);
  assign u_lo = (u >= utf8tx_pkg::SUR_LO_MIN) && (u <= utf8tx_pkg::SUR_LO_MAX);
  assign h_hi = (held >= utf8tx_pkg::SUR_HI_MIN) && (held <= utf8tx_pkg::SUR_HI_MAX);
  assign h_lo = (held >= utf8tx_pkg::SUR_LO_MIN) && (held <= utf8tx_pkg::SUR_LO_MAX);

  // high surrogate supplies bits 19:10, low surrogate bits 9:0
  assign pair = utf8tx_pkg::PLANE1 +
                (h_hi ? {1'b0, held[9:0], u[9:0]} : {1'b0, u[9:0], held[9:0]});

  always_comb begin
    unique case (byte_order)
      utf8tx_pkg::BO_UCS4_4321: cp32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
      utf8tx_pkg::BO_UCS4_3412: cp32 = {w[15:0], w[31:16]};
      utf8tx_pkg::BO_UCS4_2143: cp32 = {w[23:16], w[31:24], w[7:0], w[15:8]};
      default:                  cp32 = w;
    endcase
  end

  always_comb begin
    halted_next     = halted;
    held_valid_next = held_valid;
    held_next       = held;
    has_result      = 1'b0;
    push_entry.kind = utf8tx_pkg::KIND_RAW;
    push_entry.cp   = {{(utf8tx_pkg::CP_W-8){1'b0}}, w[7:0]};
    if (!halted) begin
      unique case (byte_order)
        utf8tx_pkg::BO_UCS4, utf8tx_pkg::BO_UCS4_4321,
        utf8tx_pkg::BO_UCS4_3412, utf8tx_pkg::BO_UCS4_2143: begin
          has_result = 1'b1;
          if (cp32 > utf8tx_pkg::CP_MAX) begin
            push_entry.kind = utf8tx_pkg::KIND_ERR;
            halted_next     = 1'b1;
          end else begin
            push_entry.kind = utf8tx_pkg::KIND_CP;
            push_entry.cp   = cp32[utf8tx_pkg::CP_W-1:0];
          end
        end
        utf8tx_pkg::BO_UCS2, utf8tx_pkg::BO_UCS2_SWAP: begin
          if (held_valid) begin
            has_result      = 1'b1;
            held_valid_next = 1'b0;
            held_next       = '0;
            if ((h_hi && u_lo) || (h_lo && u_hi)) begin
              push_entry.kind = utf8tx_pkg::KIND_CP;
              push_entry.cp   = {2'b00, pair};
            end else begin
              push_entry.kind = utf8tx_pkg::KIND_ERR;
              halted_next     = 1'b1;
            end
          end else if (!(u_hi || u_lo)) begin
            has_result      = 1'b1;
            push_entry.kind = utf8tx_pkg::KIND_CP;
            push_entry.cp   = {{(utf8tx_pkg::CP_W-16){1'b0}}, u};
          end else if (last) begin
            has_result      = 1'b1;
            push_entry.kind = utf8tx_pkg::KIND_ERR;
            halted_next     = 1'b1;
          end else begin
            held_valid_next = 1'b1;
            held_next       = u;
          end
        end
        default: begin
          has_result = 1'b1;
        end
      endcase
    end
    // stream end drops any held unit and lifts the halt
    if (last) begin
      halted_next     = 1'b0;
      held_valid_next = 1'b0;
      held_next       = '0;
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= utf8tx_pkg::BO_BYTES;
      halted     <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        byte_order <= cfg_wdata;
      end
      if (accept) begin
        halted     <= halted_next;
        held_valid <= held_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

// ===== rtl/core/utf8tx_fifo.sv =====
// Short queue of classified items between front and back ends.
// Depends on utf8tx_pkg.
module utf8tx_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8tx_pkg::entry_t  push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output utf8tx_pkg::entry_t  head
);

  utf8tx_pkg::entry_t                 slots [utf8tx_pkg::FIFO_DEPTH];
  logic [utf8tx_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [utf8tx_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [utf8tx_pkg::FIFO_AW:0]       count;

  assign full       = (count == (utf8tx_pkg::FIFO_AW+1)'(utf8tx_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/utf8tx_back.sv =====
// Back end: expands a queued item into UTF-8 bytes, sent one per cycle while
// utf8 is ready via a registered output. Depends on utf8tx_pkg, utf8tx_byte_if.
module utf8tx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  utf8tx_pkg::entry_t  head,
  output logic                pop,
  utf8tx_byte_if.source       utf8
);

  logic [7:0] bytes [6];
  logic [2:0] cnt;
  logic       cur_err;
  logic       emit;

  logic [7:0] enc [6];
  logic [2:0] enc_n;
  logic       enc_err;
  logic [31:0] c;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       error;

  assign emit = (cnt != 3'd0) && (!out_valid || utf8.ready);
  assign pop  = head_valid && ((cnt == 3'd0) || (emit && cnt == 3'd1));

  // expand the queue head into up to six bytes
  always_comb begin
    c       = {{(32-utf8tx_pkg::CP_W){1'b0}}, head.cp};
    enc_err = 1'b0;
    for (int i = 0; i < 6; i++) begin
      enc[i] = 8'h00;
    end
    enc_n = 3'd1;
    unique case (head.kind)
      utf8tx_pkg::KIND_CP: begin
        if (c <= 32'h7F) begin
          enc[0] = c[7:0];
          enc_n  = 3'd1;
        end else if (c <= 32'h7FF) begin
          enc[0] = {3'b110, c[10:6]};
          enc[1] = {2'b10, c[5:0]};
          enc_n  = 3'd2;
        end else if (c <= 32'hFFFF) begin
          enc[0] = {4'b1110, c[15:12]};
          enc[1] = {2'b10, c[11:6]};
          enc[2] = {2'b10, c[5:0]};
          enc_n  = 3'd3;
        end else if (c <= 32'h1F_FFFF) begin
          enc[0] = {5'b11110, c[20:18]};
          enc[1] = {2'b10, c[17:12]};
          enc[2] = {2'b10, c[11:6]};
          enc[3] = {2'b10, c[5:0]};
          enc_n  = 3'd4;
        end else if (c <= 32'h3F_FFFF) begin
          enc[0] = {6'b111110, c[25:24]};
          enc[1] = {2'b10, c[23:18]};
          enc[2] = {2'b10, c[17:12]};
          enc[3] = {2'b10, c[11:6]};
          enc[4] = {2'b10, c[5:0]};
          enc_n  = 3'd5;
        end else begin
          enc[0] = {7'b1111110, c[30]};
          enc[1] = {2'b10, c[29:24]};
          enc[2] = {2'b10, c[23:18]};
          enc[3] = {2'b10, c[17:12]};
          enc[4] = {2'b10, c[11:6]};
          enc[5] = {2'b10, c[5:0]};
          enc_n  = 3'd6;
        end
      end
      utf8tx_pkg::KIND_ERR: begin
        enc_err = 1'b1;
      end
      default: begin
        enc[0] = c[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cnt <= enc_n;
      end else if (emit) begin
        cnt <= cnt - 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (utf8.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= bytes[0];
      run_last <= (cnt == 3'd1);
      error    <= cur_err;
    end
    if (pop) begin
      bytes   <= enc;
      cur_err <= enc_err;
    end else if (emit) begin
      // advance to the next byte of the run
      for (int i = 0; i < 5; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[5] <= 8'h00;
    end
  end

  assign utf8.valid    = out_valid;
  assign utf8.out_byte = out_byte;
  assign utf8.run_last = run_last;
  assign utf8.error    = error;

endmodule

// ===== rtl/core/utf16_utf32_to_utf8_transcoder.sv =====
// Top level of the UTF-16/UCS-4 to UTF-8 transcoder.
// Depends on utf8tx_pkg, the two channel interfaces, front, fifo and back.
//
// Usage:
//   units : valid/ready channel carrying one raw code unit (unit_word) and
//           stream_end; a transfer happens when valid and ready are both high.
//   utf8  : valid/ready channel carrying one UTF-8 byte, run_last on the final
//           byte of each run, and error on the single error result.
//   cfg_write/cfg_wdata : writes byte_order; write only while the block is idle.
// Path: a transferred unit is written into the queue, then loaded into the back
//   end's byte buffer, then registered onto utf8. Units that give no result (a
//   held surrogate, anything while halted) are accepted and produce nothing.
// Throughput: one unit per cycle in while the queue has room and one byte per
//   cycle out while utf8 is ready; an n-byte unit takes n output transfers and
//   a four-entry queue between classifier and serialiser absorbs the difference.
// Reset (rst, synchronous): byte_order returns to byte passthrough, the held
//   surrogate and halt state clear, and the queue and output register empty.
// When utf8 stalls the output byte holds; the queue fills and then units.ready
//   drops until a slot frees.
module utf16_utf32_to_utf8_transcoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_wdata,
  utf8tx_unit_if.sink    units,
  utf8tx_byte_if.source  utf8
);

  logic               push;
  utf8tx_pkg::entry_t push_entry;
  logic               pop;
  logic               q_full;
  logic               head_valid;
  utf8tx_pkg::entry_t head;

  utf8tx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_wdata  (cfg_wdata),
    .units      (units),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  utf8tx_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  utf8tx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .utf8       (utf8)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for utf16_utf32_to_utf8_transcoder: feeds code units in
// every byte order, predicts the UTF-8 byte stream and checks each output transfer.
// Depends on utf8tx_pkg, utf8tx_unit_if and utf8tx_byte_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8tx_pkg::*;

  // byte_order code outside the defined set; behaves as byte passthrough
  localparam logic [2:0] BO_UNDEF = 3'd7;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } utf8_byte_t;

  // Tracks the transcoder state and the UTF-8 bytes still owed by the block
  class utf8_tracker;
    utf8_byte_t bytes_due[$];
    logic [2:0] order;
    logic [15:0] held_unit;
    logic held_ok;
    logic halted;
    int mismatches;
    int checked;
    int units_seen;
    int errors_seen;

    function new();
      order = BO_BYTES;
      held_unit = '0;
      held_ok = 1'b0;
      halted = 1'b0;
    endfunction

    static function logic is_high(logic [15:0] u);
      return u >= SUR_HI_MIN && u <= SUR_HI_MAX;
    endfunction

    static function logic is_low(logic [15:0] u);
      return u >= SUR_LO_MIN && u <= SUR_LO_MAX;
    endfunction

    function void push_error();
      utf8_byte_t r;
      halted = 1'b1;
      r.data = 8'h00;
      r.last = 1'b1;
      r.err = 1'b1;
      bytes_due.push_back(r);
    endfunction

    function void push_cp(logic [31:0] cp);
      logic [7:0] seq [6];
      int n;
      utf8_byte_t r;
      if (cp <= 32'h7F) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp <= 32'h7FF) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp <= 32'hFFFF) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n = 3;
      end else if (cp <= 32'h1F_FFFF) begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n = 4;
      end else if (cp <= 32'h3F_FFFF) begin
        seq[0] = {6'b111110, cp[25:24]};
        seq[1] = {2'b10, cp[23:18]};
        seq[2] = {2'b10, cp[17:12]};
        seq[3] = {2'b10, cp[11:6]};
        seq[4] = {2'b10, cp[5:0]};
        n = 5;
      end else if (cp <= CP_MAX) begin
        seq[0] = {7'b1111110, cp[30]};
        seq[1] = {2'b10, cp[29:24]};
        seq[2] = {2'b10, cp[23:18]};
        seq[3] = {2'b10, cp[17:12]};
        seq[4] = {2'b10, cp[11:6]};
        seq[5] = {2'b10, cp[5:0]};
        n = 6;
      end else begin
        push_error();
        return;
      end
      for (int k = 0; k < n; k++) begin
        r.data = seq[k];
        r.last = (k == n - 1);
        r.err = 1'b0;
        bytes_due.push_back(r);
      end
    endfunction

    function logic [31:0] pair_cp(logic [15:0] hi, logic [15:0] lo);
      return 32'(PLANE1) + (({16'h0, hi} - 32'(SUR_HI_MIN)) << 10)
             + ({16'h0, lo} - 32'(SUR_LO_MIN));
    endfunction

    function void push_ucs2(logic [15:0] u, logic fin);
      logic [15:0] h;
      if (held_ok) begin
        h = held_unit;
        held_ok = 1'b0;
        held_unit = '0;
        if (is_high(h) && is_low(u)) push_cp(pair_cp(h, u));
        else if (is_low(h) && is_high(u)) push_cp(pair_cp(u, h));
        else push_error();
      end else if (!(is_high(u) || is_low(u))) begin
        push_cp({16'h0, u});
      end else if (fin) begin
        push_error();
      end else begin
        held_unit = u;
        held_ok = 1'b1;
      end
    endfunction

    function void note_unit(logic [31:0] w, logic fin);
      utf8_byte_t r;
      units_seen++;
      if (!halted) begin
        case (order)
          BO_UCS4:      push_cp(w);
          BO_UCS4_4321: push_cp({w[7:0], w[15:8], w[23:16], w[31:24]});
          BO_UCS4_3412: push_cp({w[15:0], w[31:16]});
          BO_UCS4_2143: push_cp({w[23:16], w[31:24], w[7:0], w[15:8]});
          BO_UCS2:      push_ucs2(w[15:0], fin);
          BO_UCS2_SWAP: push_ucs2({w[7:0], w[15:8]}, fin);
          default: begin
            r.data = w[7:0];
            r.last = 1'b1;
            r.err = 1'b0;
            bytes_due.push_back(r);
          end
        endcase
      end
      if (fin) begin
        halted = 1'b0;
        held_ok = 1'b0;
        held_unit = '0;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic err);
      utf8_byte_t got;
      utf8_byte_t want;
      got.data = data;
      got.last = last;
      got.err = err;
      checked++;
      if (err) errors_seen++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte %02h last=%0b error=%0b arrived with nothing due",
                   $time, data, last, err);
        return;
      end
      want = bytes_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte %0d expected %02h last=%0b error=%0b, got %02h last=%0b error=%0b",
                   $time, checked, want.data, want.last, want.err, data, last, err);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_wdata;

  utf8tx_unit_if units ();
  utf8tx_byte_if utf8 ();

  utf16_utf32_to_utf8_transcoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata),
    .units     (units),
    .utf8      (utf8)
  );

  utf8_tracker sb;
  int cycles;
  int cfg_writes;
  logic sender_steady;
  logic sink_steady;
  logic hold_req;
  int hold_left;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_wdata = BO_BYTES;
    units.valid = 1'b0;
    units.unit_word = '0;
    units.stream_end = 1'b0;
    utf8.ready = 1'b0;
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cycles = 0;
    cfg_writes = 0;
    sb = new();
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        utf8.ready = 1'b0;
      end else begin
        utf8.ready = sink_steady || ($urandom_range(99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && utf8.valid && utf8.ready)
      sb.check_byte(utf8.out_byte, utf8.run_last, utf8.error);
  end

  task automatic send_unit(input logic [31:0] w, input logic fin);
    @(negedge clk);
    while (!sender_steady && $urandom_range(99) < 28) begin
      units.valid = 1'b0;
      @(negedge clk);
    end
    units.valid = 1'b1;
    units.unit_word = w;
    units.stream_end = fin;
    do @(posedge clk); while (!units.ready);
    sb.note_unit(w, fin);
  endtask

  task automatic send_ucs2(input logic [15:0] u, input logic fin);
    logic [15:0] pad;
    pad = 16'($urandom);
    if (sb.order == BO_UCS2_SWAP) send_unit({pad, u[7:0], u[15:8]}, fin);
    else send_unit({pad, u}, fin);
  endtask

  // Drop valid, then hold until every due byte has come and the block has settled
  task automatic wait_drained(input int settle);
    @(negedge clk);
    units.valid = 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_order(input logic [2:0] v);
    wait_drained(SETTLE_CYCLES);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.order = v;
    cfg_writes++;
  endtask

  function automatic logic [31:0] unit_for(input logic [2:0] mode, input logic [31:0] cp);
    case (mode)
      BO_UCS4_4321: return {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
      BO_UCS4_3412: return {cp[15:0], cp[31:16]};
      BO_UCS4_2143: return {cp[23:16], cp[31:24], cp[7:0], cp[15:8]};
      default:      return cp;
    endcase
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] edges [8];
    logic [15:0] u;
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
              16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
    if ($urandom_range(9) == 0) return edges[$urandom_range(7)];
    do u = 16'($urandom); while (u >= SUR_HI_MIN && u <= SUR_LO_MAX);
    return u;
  endfunction

  function automatic logic [15:0] rand_surrogate(input logic high);
    if (high) return 16'($urandom_range(SUR_HI_MAX, SUR_HI_MIN));
    return 16'($urandom_range(SUR_LO_MAX, SUR_LO_MIN));
  endfunction

  function automatic logic [31:0] rand_cp();
    int k;
    k = $urandom_range(99);
    if (k < 5) return $urandom_range(32'hFFFF_FFFF, 32'h0080_0000);
    if (k < 10) return $urandom_range(32'hDFFF, 32'hD800);
    case ($urandom_range(1, 6))
      1:       return $urandom_range(32'h7F);
      2:       return $urandom_range(32'h7FF, 32'h80);
      3:       return $urandom_range(32'hFFFF, 32'h800);
      4:       return $urandom_range(32'h1F_FFFF, 32'h1_0000);
      5:       return $urandom_range(32'h3F_FFFF, 32'h20_0000);
      default: return $urandom_range(32'h7F_FFFF, 32'h40_0000);
    endcase
  endfunction

  task automatic run_phase(input logic [2:0] mode, input int count, input logic steady,
                           input logic hold, input int pause_at);
    int sent;
    int k;
    int end_odds;
    logic paused;
    logic [15:0] s;
    logic [15:0] t;
    write_order(mode);
    sender_steady = steady || hold;
    sink_steady = steady;
    if (hold) hold_req = 1'b1;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      // end the stream sooner while halted so that output resumes
      end_odds = sb.halted ? 3 : 10;
      if (!paused && pause_at >= 0 && sent >= pause_at) begin
        wait_drained(0);
        paused = 1'b1;
      end
      if (mode == BO_UCS2 || mode == BO_UCS2_SWAP) begin
        k = $urandom_range(99);
        if (k < 55) begin
          send_ucs2(rand_bmp(), $urandom_range(end_odds - 1) == 0);
          sent += 1;
        end else if (k < 80) begin
          s = rand_surrogate(1'b1);
          t = rand_surrogate(1'b0);
          if ($urandom_range(4) == 0) begin
            send_ucs2(t, 1'b0);
            send_ucs2(s, $urandom_range(end_odds - 1) == 0);
          end else begin
            send_ucs2(s, 1'b0);
            send_ucs2(t, $urandom_range(end_odds - 1) == 0);
          end
          sent += 2;
        end else if (k < 93) begin
          s = rand_surrogate(1'($urandom_range(1)));
          t = $urandom_range(1) ? rand_bmp() : rand_surrogate(utf8_tracker::is_high(s));
          send_ucs2(s, 1'b0);
          send_ucs2(t, $urandom_range(end_odds - 1) == 0);
          sent += 2;
        end else begin
          send_ucs2(rand_surrogate(1'($urandom_range(1))), 1'b1);
          sent += 1;
        end
      end else if (mode >= BO_UCS4 && mode <= BO_UCS4_2143) begin
        send_unit(unit_for(mode, rand_cp()), $urandom_range(end_odds - 1) == 0);
        sent += 1;
      end else begin
        send_unit($urandom, $urandom_range(end_odds - 1) == 0);
        sent += 1;
      end
    end
    sender_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Byte passthrough straight out of reset
    send_unit(32'h0000_0000, 1'b0);
    send_unit(32'hFFFF_FFFF, 1'b1);

    // UCS-4 length boundaries, a surrogate value, then an oversized code point
    write_order(BO_UCS4);
    send_unit(32'h0000_007F, 1'b0);
    send_unit(32'h0000_0080, 1'b0);
    send_unit(32'h0000_D800, 1'b0);
    send_unit(32'h0001_0000, 1'b0);
    send_unit(32'h003F_FFFF, 1'b0);
    send_unit(32'h007F_FFFF, 1'b0);
    send_unit(32'hFFFF_FFFF, 1'b0);
    send_unit(32'h0000_0041, 1'b0);
    send_unit(32'h0000_0042, 1'b1);

    write_order(BO_UCS4_4321);
    send_unit(unit_for(BO_UCS4_4321, 32'h005A_BCDE), 1'b0);
    write_order(BO_UCS4_3412);
    send_unit(unit_for(BO_UCS4_3412, 32'h0012_3456), 1'b0);
    write_order(BO_UCS4_2143);
    send_unit(unit_for(BO_UCS4_2143, 32'h0000_07FF), 1'b1);

    // UCS-2 pairs in both orders, a broken pair and the halt that follows
    write_order(BO_UCS2);
    send_ucs2(16'hD800, 1'b0);
    send_ucs2(16'hDC00, 1'b0);
    send_ucs2(16'hDFFF, 1'b0);
    send_ucs2(16'hDBFF, 1'b0);
    send_ucs2(16'hD800, 1'b0);
    send_ucs2(16'h0041, 1'b0);
    send_ucs2(16'h0042, 1'b1);

    // Held surrogate survives a detour through another mode
    send_ucs2(16'hD801, 1'b0);
    write_order(BO_UNDEF);
    send_unit(32'h1234_565A, 1'b0);
    write_order(BO_UCS2);
    send_ucs2(16'hDC37, 1'b0);

    // Held surrogate is dropped by a stream end in another mode; lone one then errors
    send_ucs2(16'hD802, 1'b0);
    write_order(BO_BYTES);
    send_unit(32'h0000_0000, 1'b1);
    write_order(BO_UCS2);
    send_ucs2(16'hDC00, 1'b1);

    write_order(BO_UCS2_SWAP);
    send_ucs2(16'hFFFF, 1'b1);

    run_phase(BO_UCS2, 40, 1'b1, 1'b0, -1);
    run_phase(BO_UCS4, 20, 1'b0, 1'b1, -1);
    run_phase(BO_UCS2_SWAP, 25, 1'b0, 1'b0, -1);
    run_phase(BO_UCS4_4321, 20, 1'b0, 1'b0, -1);
    run_phase(BO_BYTES, 15, 1'b0, 1'b0, -1);
    run_phase(BO_UCS4_3412, 20, 1'b0, 1'b0, -1);
    run_phase(BO_UCS2, 25, 1'b0, 1'b0, 12);
    run_phase(BO_UCS4_2143, 20, 1'b0, 1'b0, -1);
    run_phase(BO_UNDEF, 10, 1'b0, 1'b0, -1);
    run_phase(BO_UCS2_SWAP, 15, 1'b0, 1'b0, -1);

    wait_drained(20);
    $display("Covered %0d code units over %0d byte-order writes; checked %0d output bytes,",
             sb.units_seen, cfg_writes, sb.checked);
    $display("%0d of them error markers; %0d mismatches, %0d bytes still due.",
             sb.errors_seen, sb.mismatches, sb.bytes_due.size());
    if (sb.mismatches == 0 && sb.bytes_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
